// ----- src/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// Opcodes, wildcard bytes and the word that ripples down the cell chain.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_PATTERN_DEF = 128;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  // One input word travelling along the chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic       vld;
    op_t        op;
    logic [7:0] ch;
    logic       carry;  // reachability entering this position from the left
    logic       done;   // append placed, or end position located
    logic       match;  // reachable bit of the end position, once located
  } wave_t;

endpackage

// ----- src/wpm_cell.sv -----
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position
// Holds one pattern byte, its used bit and its reachable bit, and updates
// them as a word passes, handing the word on to the next position.
// ----------------------------------------------------------------------------
module wpm_cell #(
  parameter logic R_INIT = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  wpm_pkg::wave_t win,
  output wpm_pkg::wave_t wout
);

  logic           used;
  logic           used_next;
  logic [7:0]     pat;
  logic [7:0]     pat_next;
  logic           r;
  logic           r_next;
  logic           star;
  logic           hit;
  wpm_pkg::wave_t wave_next;

  always_comb begin
    star      = used && (pat == wpm_pkg::CH_STAR);
    hit       = used && !star && ((pat == wpm_pkg::CH_ANY) || (pat == win.ch));
    used_next = used;
    pat_next  = pat;
    r_next    = r;
    wave_next = win;
    wave_next.carry = 1'b0;
    if (win.vld) begin
      unique case (win.op)
        wpm_pkg::OP_CLEAR: begin
          used_next = 1'b0;
          r_next    = win.carry;
        end
        wpm_pkg::OP_APPEND: begin
          if (!used && !win.done) begin
            // first free position takes the byte
            used_next       = 1'b1;
            pat_next        = win.ch;
            wave_next.done  = 1'b1;
            wave_next.carry = r && (win.ch == wpm_pkg::CH_STAR);
          end else if (!used) begin
            r_next = win.carry;
          end
        end
        wpm_pkg::OP_TEXT: begin
          r_next          = win.carry || (r && star);
          wave_next.carry = (r && hit) || (r_next && star);
        end
        wpm_pkg::OP_END: begin
          if (!used && !win.done) begin
            wave_next.done  = 1'b1;
            wave_next.match = r;
          end
          // rearm
          r_next          = win.carry;
          wave_next.carry = win.carry && star;
        end
        default: begin
          r_next = r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      r        <= R_INIT;
      wout.vld <= 1'b0;
    end else if (adv) begin
      used     <= used_next;
      r        <= r_next;
      wout.vld <= wave_next.vld;
    end
    if (adv) begin
      pat        <= pat_next;
      wout.op    <= wave_next.op;
      wout.ch    <= wave_next.ch;
      wout.carry <= wave_next.carry;
      wout.done  <= wave_next.done;
      wout.match <= wave_next.match;
    end
  end

endmodule

// ----- src/wpm_tail.sv -----
// ----------------------------------------------------------------------------
// wpm_tail: end of the chain
// Holds the reachable bit of the full-length position and the overflow flag,
// and registers the result word for an end of text.
// ----------------------------------------------------------------------------
module wpm_tail (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  wpm_pkg::wave_t win,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           is_match,
  output logic           pattern_overflow
);

  logic r;
  logic r_next;
  logic ovf;
  logic ovf_next;
  logic load;
  logic out_valid_next;
  logic match_now;

  always_comb begin
    r_next    = r;
    ovf_next  = ovf;
    load      = 1'b0;
    match_now = win.done ? win.match : r;
    if (win.vld) begin
      unique case (win.op)
        wpm_pkg::OP_CLEAR: begin
          ovf_next = 1'b0;
          r_next   = win.carry;
        end
        wpm_pkg::OP_APPEND: begin
          // no free position left: drop the byte
          if (!win.done) ovf_next = 1'b1;
          else r_next = win.carry;
        end
        wpm_pkg::OP_TEXT: begin
          r_next = win.carry;
        end
        wpm_pkg::OP_END: begin
          r_next = win.carry;
          load   = 1'b1;
        end
        default: begin
          r_next = r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (adv && load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r         <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (adv) begin
        r   <= r_next;
        ovf <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      is_match         <= match_now;
      pattern_overflow <= ovf;
    end
  end

endmodule

// ----- src/wildcard_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: whole-string wildcard matcher
// A row of position cells with a tail; each input word ripples down the row.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall, opcode, char_byte): clear the pattern,
// append a pattern byte, feed a text byte, or end the text. '?' matches any
// byte, '*' any run of bytes. One word is taken every cycle while the
// output side is not blocked.
// Each word walks the row of MAX_PATTERN cells, one cell per cycle while the
// row is not held, and the tail then registers the result of an end of text
// onto the output channel (out_valid / out_stall, is_match, pattern_overflow).
// Throughput is one word per cycle while the row is not held; words overlap
// in the row.
// Other opcodes give no result. Appends past MAX_PATTERN bytes are dropped
// and set pattern_overflow until the next clear.
// While a result waits with out_stall high the whole row holds and in_stall
// is raised; the waiting result stays put until taken.
// Reset empties the pattern, clears the overflow flag and arms the matcher
// with only the start position reachable.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_match,
  output logic       pattern_overflow
);

  logic           adv;
  wpm_pkg::op_t   op_in;
  wpm_pkg::wave_t w_in;
  wpm_pkg::wave_t wv [0:MAX_PATTERN];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign op_in    = wpm_pkg::op_t'(opcode);
  assign wv[0]    = w_in;

  // rearming words inject reachability into the start position
  always_comb begin
    w_in.vld   = in_valid;
    w_in.op    = op_in;
    w_in.ch    = char_byte;
    w_in.carry = (op_in == wpm_pkg::OP_CLEAR) || (op_in == wpm_pkg::OP_END);
    w_in.done  = 1'b0;
    w_in.match = 1'b0;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wpm_cell #(
      .R_INIT ((i == 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .win  (wv[i]),
      .wout (wv[i+1])
    );
  end

  wpm_tail u_tail (
    .clk              (clk),
    .rst              (rst),
    .adv              (adv),
    .win              (wv[MAX_PATTERN]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .is_match         (is_match),
    .pattern_overflow (pattern_overflow)
  );

endmodule

// ----- tb/sv/wpm_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_tb_pkg: match scoreboard for the wildcard pattern matcher bench
// Tracks pattern bytes and reachable positions word by word, queues the
// verdict of each end of text and compares it with what the block reports.
// ----------------------------------------------------------------------------
package wpm_tb_pkg;

  localparam int PAT_CAP = wpm_pkg::MAX_PATTERN_DEF;

  typedef struct packed {
    logic is_match;
    logic overflow;
  } verdict_t;

  class match_scoreboard;
    logic [7:0]     pat [PAT_CAP];
    int unsigned    plen;
    bit [PAT_CAP:0] reach;
    bit             dropped;
    verdict_t       verdicts[$];
    int             errors;

    function new();
      plen    = 0;
      dropped = 0;
      errors  = 0;
      rearm();
    endfunction

    // A star may match the empty run: carry reachability across it, left to right.
    function void spread_stars();
      for (int unsigned i = 0; i < plen; i++)
        if (reach[i] && pat[i] == wpm_pkg::CH_STAR) reach[i + 1] = 1'b1;
    endfunction

    function void rearm();
      reach    = '0;
      reach[0] = 1'b1;
      spread_stars();
    endfunction

    function void note_word(wpm_pkg::op_t op, logic [7:0] ch);
      bit [PAT_CAP:0] nxt;
      case (op)
        wpm_pkg::OP_CLEAR: begin
          plen    = 0;
          dropped = 0;
          rearm();
        end
        wpm_pkg::OP_APPEND: begin
          if (plen >= PAT_CAP) begin
            dropped = 1'b1;
          end else begin
            pat[plen]        = ch;
            reach[plen + 1]  = 1'b0;
            plen++;
            spread_stars();
          end
        end
        wpm_pkg::OP_TEXT: begin
          nxt = '0;
          for (int unsigned i = 0; i < plen; i++) begin
            if (reach[i]) begin
              if (pat[i] == wpm_pkg::CH_STAR) nxt[i] = 1'b1;
              else if (pat[i] == wpm_pkg::CH_ANY || pat[i] == ch) nxt[i + 1] = 1'b1;
            end
          end
          reach = nxt;
          spread_stars();
        end
        default: begin
          verdicts.insert(verdicts.size(), verdict_t'{reach[plen], dropped});
          rearm();
        end
      endcase
    endfunction

    function void check_result(logic got_match, logic got_ovf);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_match=%0b overflow=%0b",
                 $time, got_match, got_ovf);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got_match !== want.is_match) begin
        $display("%0t: is_match expected %0b actual %0b", $time, want.is_match, got_match);
        errors++;
      end
      if (got_ovf !== want.overflow) begin
        $display("%0t: pattern_overflow expected %0b actual %0b",
                 $time, want.overflow, got_ovf);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: bench for the wildcard pattern matcher
// Directed words first, then random patterns and texts (many built to match,
// some with near misses, appends in mid-text and overfilled patterns) under
// changing sender idling and receiver stalls; every verdict is checked.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET    = 1800;
  localparam int WATCHDOG_LIMIT = 4000;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic         in_stall;
  wpm_pkg::op_t opcode    = wpm_pkg::OP_CLEAR;
  logic [7:0]   char_byte = 8'h00;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic         is_match;
  logic         pattern_overflow;

  wpm_tb_pkg::match_scoreboard sb = new();

  int sent  = 0;
  int stage = 0;
  int quiet = 0;

  wildcard_pattern_matcher dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .char_byte        (char_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .is_match         (is_match),
    .pattern_overflow (pattern_overflow)
  );

  always #2 clk = ~clk;

  // Stage 0: no idling; 1: sender idle; 2: receiver stalls; 3: both, lightly.
  function automatic bit roll_idle(bit sender);
    int pct;
    case (stage)
      1:       pct = sender ? 67 : 0;
      2:       pct = sender ? 0 : 67;
      3:       pct = 33;
      default: pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(is_match, pattern_overflow);
    out_stall <= roll_idle(1'b0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input wpm_pkg::op_t op, input logic [7:0] ch);
    while (roll_idle(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    char_byte <= ch;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, ch);
    sent++;
    stage = (sent / 150) % 4;
  endtask

  function automatic logic [7:0] pat_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return wpm_pkg::CH_STAR;
    if (r < 5) return wpm_pkg::CH_ANY;
    if (r < 9) return 8'h61 + 8'($urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Send one text and its end; follow builds a text the current pattern accepts.
  task automatic send_text(input bit follow);
    logic [7:0] txt[$];
    int         cut;
    if (follow) begin
      for (int unsigned i = 0; i < sb.plen; i++) begin
        if (sb.pat[i] == wpm_pkg::CH_STAR)
          repeat ($urandom_range(0, 3)) txt.insert(txt.size(), text_byte());
        else if (sb.pat[i] == wpm_pkg::CH_ANY) txt.insert(txt.size(), text_byte());
        else txt.insert(txt.size(), sb.pat[i]);
      end
      // near miss: overwrite one byte
      if (txt.size() > 0 && $urandom_range(0, 3) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = text_byte();
    end else begin
      repeat ($urandom_range(0, 12)) txt.insert(txt.size(), text_byte());
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, txt.size()) : -1;
    for (int i = 0; i <= txt.size(); i++) begin
      if (i == cut) send_word(wpm_pkg::OP_APPEND, pat_byte());
      if (i < txt.size()) send_word(wpm_pkg::OP_TEXT, txt[i]);
    end
    send_word(wpm_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty pattern against empty and non-empty text
    send_word(wpm_pkg::OP_CLEAR, 8'h55);
    send_word(wpm_pkg::OP_END, 8'hFF);
    send_word(wpm_pkg::OP_TEXT, 8'h78);
    send_word(wpm_pkg::OP_END, 8'h00);
    // byte extremes as literals
    send_word(wpm_pkg::OP_APPEND, 8'h00);
    send_word(wpm_pkg::OP_APPEND, 8'hFF);
    send_word(wpm_pkg::OP_TEXT, 8'h00);
    send_word(wpm_pkg::OP_TEXT, 8'hFF);
    send_word(wpm_pkg::OP_END, 8'hAA);
    // star on empty text, then star, literal and any-byte together
    send_word(wpm_pkg::OP_CLEAR, 8'hFF);
    send_word(wpm_pkg::OP_APPEND, wpm_pkg::CH_STAR);
    send_word(wpm_pkg::OP_END, 8'h00);
    send_word(wpm_pkg::OP_APPEND, 8'h61);
    send_word(wpm_pkg::OP_APPEND, wpm_pkg::CH_ANY);
    send_word(wpm_pkg::OP_TEXT, 8'h7A);
    send_word(wpm_pkg::OP_TEXT, 8'h61);
    send_word(wpm_pkg::OP_TEXT, 8'h71);
    send_word(wpm_pkg::OP_END, 8'h00);
    // append in mid-text, then a dead set
    send_word(wpm_pkg::OP_TEXT, 8'h61);
    send_word(wpm_pkg::OP_APPEND, 8'h62);
    send_word(wpm_pkg::OP_TEXT, 8'h62);
    send_word(wpm_pkg::OP_END, 8'h00);
    send_word(wpm_pkg::OP_CLEAR, 8'h00);
    send_word(wpm_pkg::OP_APPEND, 8'h61);
    send_word(wpm_pkg::OP_TEXT, 8'h62);
    send_word(wpm_pkg::OP_TEXT, 8'h61);
    send_word(wpm_pkg::OP_END, 8'h00);

    for (int seq = 0; sent < ITEM_TARGET; seq++) begin
      kind = $urandom_range(0, 9);
      if (seq % 40 == 7) begin
        // fill the pattern near or past its capacity, then check that any drop is reported
        send_word(wpm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(wpm_tb_pkg::PAT_CAP - 2, wpm_tb_pkg::PAT_CAP + 6))
          send_word(wpm_pkg::OP_APPEND, pat_byte());
        send_text(1'b1);
        send_text(1'b0);
      end else if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(wpm_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) < 7) send_word(wpm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 10)) send_word(wpm_pkg::OP_APPEND, pat_byte());
        repeat ($urandom_range(1, 4)) send_text($urandom_range(0, 1));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (wpm_tb_pkg::PAT_CAP + 16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- wildcard_pattern_matcher.f -----
src/wpm_pkg.sv
src/wpm_cell.sv
src/wpm_tail.sv
src/wildcard_pattern_matcher.sv
tb/sv/wpm_tb_pkg.sv
tb/sv/tb_top.sv
